@@ rtl/kasr_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and sequencer states for the key-to-analog slew ramp.
// No dependencies; compile first.
package kasr_pkg;

    // Defaults for the top-level parameters
    localparam int CHANNELS_DEF = 8;
    localparam int VFB_DEF      = 14;

    // Field widths
    localparam int OP_W       = 2;
    localparam int CHAN_W     = 3;
    localparam int ELAPSED_W  = 16;
    localparam int LEVEL_W    = 16;
    localparam int TIME_W     = 20;
    localparam int FLOOR_W    = 15;
    localparam int MASK_W     = 8;
    localparam int HOLD_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // tap_floor is given with this many fraction bits
    localparam int FLOOR_FRAC = 14;

    // Register reset values
    localparam logic [TIME_W-1:0]  RAMP_UP_RST    = TIME_W'(100000);
    localparam logic [TIME_W-1:0]  RAMP_DOWN_RST  = TIME_W'(80000);
    localparam logic               REVERSAL_RST   = 1'b1;
    localparam logic [TIME_W-1:0]  TAP_WINDOW_RST = TIME_W'(150000);
    localparam logic [FLOOR_W-1:0] TAP_FLOOR_RST  = FLOOR_W'(9830);
    localparam logic [MASK_W-1:0]  TAP_MASK_RST   = MASK_W'(255);

    typedef enum logic [OP_W-1:0] {
        OP_DUAL   = 2'd0,
        OP_SINGLE = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAMP_UP    = 3'd0,
        CFG_RAMP_DOWN  = 3'd1,
        CFG_REVERSAL   = 3'd2,
        CFG_TAP_WINDOW = 3'd3,
        CFG_TAP_FLOOR  = 3'd4,
        CFG_TAP_MASK   = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_PREP,
        S_MUL,
        S_TDIV,
        S_TGT,
        S_DIR,
        S_SDIV,
        S_RAMP,
        S_DONE
    } t_state;

endpackage

@@ rtl/kasr_in_if.sv @@
`timescale 1ns / 1ps
// Request channel of the slew ramp: valid/ready plus one key tick.
// Depends on kasr_pkg.
interface kasr_in_if;
    import kasr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [CHAN_W-1:0]    channel;
    logic                 positive_pressed;
    logic                 negative_pressed;
    logic [ELAPSED_W-1:0] elapsed;

    modport source (
        output valid, operation, channel, positive_pressed, negative_pressed, elapsed,
        input  ready
    );

    modport sink (
        input  valid, operation, channel, positive_pressed, negative_pressed, elapsed,
        output ready
    );

endinterface

@@ rtl/kasr_out_if.sv @@
`timescale 1ns / 1ps
// Result channel of the slew ramp: valid/ready plus level and status bits.
// Depends on kasr_pkg.
interface kasr_out_if;
    import kasr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [LEVEL_W-1:0] level;
    logic                      ramping;
    logic                      tap_active;

    modport source (
        output valid, level, ramping, tap_active,
        input  ready
    );

    modport sink (
        input  valid, level, ramping, tap_active,
        output ready
    );

endinterface

@@ rtl/kasr_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kasr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/kasr_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for quotients known to fit QW bits.
// Dividend = {i_hi, i_lo} with i_hi < i_den. Depends on kasr_pkg for parameter defaults.
module kasr_div #(
    parameter int QW    = kasr_pkg::VFB_DEF + 2,
    parameter int DEN_W = kasr_pkg::TIME_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DEN_W-1:0] i_hi,
    input  logic [QW-1:0]    i_lo,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [QW-1:0]    o_quot
);

    localparam int CW = $clog2(QW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [QW-1:0]    r_lo;
    logic [QW-1:0]    r_quot;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             ge;

    assign trial     = {r_rem, r_lo[QW-1]};
    assign ge        = trial >= {1'b0, r_den};
    assign trial_sub = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Shift one dividend bit into the partial remainder per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_hi;
            r_lo   <= i_lo;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            r_lo   <= {r_lo[QW-2:0], 1'b0};
            r_quot <= {r_quot[QW-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ rtl/key_to_analog_slew_ramp.sv @@
`timescale 1ns / 1ps
// Key-to-analog slew ramp: key ticks per channel in, slew-limited level out.
// Depends on kasr_pkg, kasr_in_if, kasr_out_if, kasr_ram and kasr_div.
//
// Usage:
//   i_in carries one request per tick: operation (dual-key update, single-key
//   update, channel clear), channel, the two key states and the elapsed time
//   in microseconds. o_out returns one result per request: the channel level
//   (signed, VALUE_FRACTION_BITS fraction bits, low 16 bits), a ramping flag
//   and the tap flag. Registers are written on i_cfg_we through i_cfg_index
//   and i_cfg_data; the user must write them only while no request is in
//   flight, which the block itself does not enforce. A clear, the unused code
//   or an absent channel goes from acceptance through the read and load states
//   to the done state. An update adds prep, target and direction and then,
//   unless the ramp time is zero, the ramp state, preceded by the step division
//   when the step does not saturate; a scaled tap adds the multiply and tap
//   division states. The single bit-serial divider, one quotient bit per cycle,
//   serves both; a new request is taken the cycle after the result is stored.
//   Per-channel state lives in a small RAM with one valid bit per channel;
//   reset clears the valid bits, so every channel reads as zero at once and
//   requests are taken right after reset. The result sits in an output
//   register: a stalled receiver does not block acceptance of the next
//   request, only its completion.
module key_to_analog_slew_ramp #(
    parameter int CHANNELS            = kasr_pkg::CHANNELS_DEF,
    parameter int VALUE_FRACTION_BITS = kasr_pkg::VFB_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [kasr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [kasr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    kasr_in_if.sink                           i_in,
    kasr_out_if.source                        o_out
);
    import kasr_pkg::*;

    localparam int VFB    = VALUE_FRACTION_BITS;
    localparam int MAG_W  = VFB + 1;           // magnitude up to 1.0
    localparam int LW     = VFB + 2;           // stored signed level / target
    localparam int DW     = VFB + 3;           // signed differences
    localparam int QW     = VFB + 2;           // quotient bits
    localparam int PW     = MAG_W + TIME_W;    // tap product
    localparam int HS_W   = HOLD_W + 1;
    localparam int RT4_W  = TIME_W + 2;
    localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CXW    = (AW > CHAN_W) ? AW : CHAN_W;
    localparam int EW     = 2 * LW + HOLD_W + 3;
    localparam int LXW    = (LW > LEVEL_W) ? LW : LEVEL_W;
    localparam int FSH_L  = (VFB >= FLOOR_FRAC) ? VFB - FLOOR_FRAC : 0;
    localparam int FSH_R  = (VFB < FLOOR_FRAC) ? FLOOR_FRAC - VFB : 0;
    localparam int FXW    = FLOOR_W + FSH_L;
    localparam int CMPW   = (FXW > MAG_W) ? FXW : MAG_W;
    localparam int NEAR_I = ((1 << VFB) + 50) / 100;

    localparam logic [MAG_W-1:0]       ONE_M  = {1'b1, {VFB{1'b0}}};
    localparam logic signed [LW-1:0]   ONE_S  = {2'b01, {VFB{1'b0}}};
    localparam logic [DW-1:0]          NEAR_D = DW'(NEAR_I);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [TIME_W-1:0]  r_ramp_up;
    logic [TIME_W-1:0]  r_ramp_down;
    logic               r_reversal;
    logic [TIME_W-1:0]  r_tap_window;
    logic [FLOOR_W-1:0] r_tap_floor;
    logic [MASK_W-1:0]  r_tap_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_up    <= RAMP_UP_RST;
            r_ramp_down  <= RAMP_DOWN_RST;
            r_reversal   <= REVERSAL_RST;
            r_tap_window <= TAP_WINDOW_RST;
            r_tap_floor  <= TAP_FLOOR_RST;
            r_tap_mask   <= TAP_MASK_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RAMP_UP:    r_ramp_up    <= i_cfg_data;
                CFG_RAMP_DOWN:  r_ramp_down  <= i_cfg_data;
                CFG_REVERSAL:   r_reversal   <= i_cfg_data[0];
                CFG_TAP_WINDOW: r_tap_window <= i_cfg_data;
                CFG_TAP_FLOOR:  r_tap_floor  <= i_cfg_data[FLOOR_W-1:0];
                CFG_TAP_MASK:   r_tap_mask   <= i_cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer, request and working registers
    // ------------------------------------------------------------------
    t_state r_state;
    t_state n_state;

    logic [OP_W-1:0]        r_op;
    logic [CHAN_W-1:0]      r_chan;
    logic                   r_p;
    logic                   r_n;
    logic [ELAPSED_W-1:0]   r_dt;
    logic                   r_oor;

    logic signed [LW-1:0]   r_lvl;
    logic signed [LW-1:0]   r_tgt;
    logic [HOLD_W-1:0]      r_hold;
    logic                   r_lp;
    logic                   r_ln;
    logic                   r_tap;
    logic                   r_press;
    logic                   r_tneg;
    logic [MAG_W-1:0]       r_tmag;
    logic [MAG_W-1:0]       r_floor;
    logic [MAG_W-1:0]       r_span;
    logic [QW-1:0]          r_step;

    logic                      r_ovalid;
    logic signed [LEVEL_W-1:0] r_olevel;
    logic                      r_oramp;
    logic                      r_otap;

    logic [CHANNELS-1:0]    r_valid;

    // Handshake and strobes from the output decode
    logic in_ready;
    logic div_start;
    logic div_for_step;
    logic done_fire;
    logic out_free;

    assign out_free = !r_ovalid || o_out.ready;

    // ------------------------------------------------------------------
    // Channel state RAM: {level, target, hold, last_pos, last_neg, tap}
    // ------------------------------------------------------------------
    logic [CXW-1:0] chan_x;
    logic [AW-1:0]  addr;
    logic [EW-1:0]  ram_rdata;
    logic [EW-1:0]  ram_wdata;
    logic           ram_we;
    logic [EW-1:0]  entry;

    assign chan_x    = CXW'(r_chan);
    assign addr      = chan_x[AW-1:0];
    assign ram_wdata = {r_lvl, r_tgt, r_hold, r_lp, r_ln, r_tap};
    assign ram_we    = done_fire && !r_oor && (r_op inside {OP_DUAL, OP_SINGLE});

    kasr_ram #(
        .WIDTH (EW),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (addr),
        .i_wdata (ram_wdata),
        .i_raddr (addr),
        .o_rdata (ram_rdata)
    );

    // A channel never written since reset or clear reads as all zero
    assign entry = r_valid[addr] ? ram_rdata : '0;

    logic signed [LW-1:0] e_lvl;
    logic signed [LW-1:0] e_tgt;
    logic [HOLD_W-1:0]    e_hold;
    logic                 e_lp;
    logic                 e_ln;
    logic                 e_tap;

    assign {e_lvl, e_tgt, e_hold, e_lp, e_ln, e_tap} = entry;

    // ------------------------------------------------------------------
    // Load stage: reversal snap and hold-time update
    // ------------------------------------------------------------------
    logic                 zero_out;
    logic                 rev;
    logic                 key_any;
    logic [HOLD_W-1:0]    hold0;
    logic [HS_W-1:0]      hsum;
    logic [HOLD_W-1:0]    hold_upd;

    assign zero_out = r_oor || (r_op == OP_CLEAR);
    // Dual mode with reversal enabled: pressing the key opposite to the one held alone last tick
    assign rev      = (r_op == OP_DUAL) && r_reversal &&
                      ((r_p && e_ln && !e_lp) || (r_n && e_lp && !e_ln));
    assign key_any  = (r_op == OP_DUAL) ? (r_p || r_n) : r_p;
    assign hold0    = rev ? '0 : e_hold;
    assign hsum     = {1'b0, hold0} + HS_W'(r_dt);
    // Clear the hold time when no key is down, else saturate it at full scale
    assign hold_upd = !key_any ? '0 : (hsum[HOLD_W] ? '1 : hsum[HOLD_W-1:0]);

    // ------------------------------------------------------------------
    // Prep stage: tap eligibility and scaled floor
    // ------------------------------------------------------------------
    logic             tap_elig;
    logic [FXW-1:0]   fsc;
    logic [MAG_W-1:0] floor_m;

    assign tap_elig = r_tap_mask[r_chan] && (r_hold <= HOLD_W'(r_tap_window));
    assign fsc      = (FXW'(r_tap_floor) << FSH_L) >> FSH_R;
    assign floor_m  = (CMPW'(fsc) > CMPW'(ONE_M)) ? ONE_M : fsc[MAG_W-1:0];

    // Tap product (ONE - floor) * hold, straight into the divider at start
    logic [PW-1:0] prod;

    assign prod = r_span * r_hold[TIME_W-1:0];

    // ------------------------------------------------------------------
    // Target stage: signed target and the 0.01 dead band
    // ------------------------------------------------------------------
    logic signed [LW-1:0] tpos;
    logic signed [LW-1:0] tval;
    logic signed [DW-1:0] tdiff;
    logic [DW-1:0]        tdiff_mag;

    assign tpos      = signed'({1'b0, r_tmag});
    assign tval      = r_tneg ? -tpos : tpos;
    assign tdiff     = DW'(r_tgt) - DW'(tval);
    assign tdiff_mag = tdiff[DW-1] ? -tdiff : tdiff;

    // ------------------------------------------------------------------
    // Direction stage: pick ramp time, check for instant or saturated step
    // ------------------------------------------------------------------
    logic [LW-1:0]     mag_tgt;
    logic [LW-1:0]     mag_lvl;
    logic              ramp_up;
    logic [TIME_W-1:0] rt_sel;
    logic              rt_zero;
    logic              step_sat;

    assign mag_tgt  = r_tgt[LW-1] ? -r_tgt : r_tgt;
    assign mag_lvl  = r_lvl[LW-1] ? -r_lvl : r_lvl;
    assign ramp_up  = (r_op == OP_DUAL) ? (mag_tgt > mag_lvl) : (r_lvl < r_tgt);
    assign rt_sel   = ramp_up ? r_ramp_up : r_ramp_down;
    assign rt_zero  = (rt_sel == '0);
    // dt >= 4*rt means a step of at least four times full scale: no division needed
    assign step_sat = RT4_W'(r_dt) >= {rt_sel, 2'b00};

    // ------------------------------------------------------------------
    // Shared bit-serial divider
    // ------------------------------------------------------------------
    logic [TIME_W-1:0] div_hi;
    logic [QW-1:0]     div_lo;
    logic [TIME_W-1:0] div_den;
    logic              div_busy;
    logic              div_done;
    logic [QW-1:0]     div_quot;

    assign div_hi  = div_for_step ? TIME_W'(r_dt[ELAPSED_W-1:2]) : TIME_W'(prod[PW-1:QW]);
    assign div_lo  = div_for_step ? {r_dt[1:0], {VFB{1'b0}}} : prod[QW-1:0];
    assign div_den = div_for_step ? rt_sel : r_tap_window;

    kasr_div #(
        .QW    (QW),
        .DEN_W (TIME_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_hi    (div_hi),
        .i_lo    (div_lo),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // ------------------------------------------------------------------
    // Ramp stage: move by the step, clamp at the target
    // ------------------------------------------------------------------
    logic signed [DW-1:0] rdiff;
    logic [DW-1:0]        rmag;
    logic signed [LW-1:0] lvl_ramp;

    assign rdiff = DW'(r_tgt) - DW'(r_lvl);
    assign rmag  = rdiff[DW-1] ? -rdiff : rdiff;

    always_comb begin
        if (rmag <= DW'(r_step)) begin
            lvl_ramp = r_tgt;
        end else if (rdiff[DW-1]) begin
            lvl_ramp = r_lvl - signed'(r_step);
        end else begin
            lvl_ramp = r_lvl + signed'(r_step);
        end
    end

    // Result fields
    logic signed [DW-1:0]  ldiff;
    logic [DW-1:0]         lmag;
    logic signed [LXW-1:0] lvl_x;

    assign ldiff = DW'(r_lvl) - DW'(r_tgt);
    assign lmag  = ldiff[DW-1] ? -ldiff : ldiff;
    assign lvl_x = LXW'(r_lvl);

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) n_state = S_READ;
            end
            S_READ: n_state = S_LOAD;
            S_LOAD: begin
                // Clear, unused codes and absent channels only report
                if (r_oor || !(r_op inside {OP_DUAL, OP_SINGLE})) n_state = S_DONE;
                else n_state = S_PREP;
            end
            S_PREP: begin
                if (r_press && tap_elig && (r_tap_window != '0)) n_state = S_MUL;
                else n_state = S_TGT;
            end
            S_MUL:  n_state = S_TDIV;
            S_TDIV: begin
                if (div_done) n_state = S_TGT;
            end
            S_TGT:  n_state = S_DIR;
            S_DIR: begin
                if (rt_zero) n_state = S_DONE;
                else if (step_sat) n_state = S_RAMP;
                else n_state = S_SDIV;
            end
            S_SDIV: begin
                if (div_done) n_state = S_RAMP;
            end
            S_RAMP: n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        in_ready     = 1'b0;
        div_start    = 1'b0;
        div_for_step = 1'b0;
        done_fire    = 1'b0;
        case (r_state)
            S_IDLE: in_ready = 1'b1;
            S_MUL:  div_start = 1'b1;
            S_DIR: begin
                div_for_step = 1'b1;
                div_start    = !rt_zero && !step_sat;
            end
            S_DONE: done_fire = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_valid  <= '0;
        end else begin
            r_state <= n_state;
            if (done_fire) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            // Mark written channels, drop cleared ones
            if (done_fire && !r_oor) begin
                if (r_op inside {OP_DUAL, OP_SINGLE}) begin
                    r_valid[addr] <= 1'b1;
                end else if (r_op == OP_CLEAR) begin
                    r_valid[addr] <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    r_op   <= i_in.operation;
                    r_chan <= i_in.channel;
                    r_p    <= i_in.positive_pressed;
                    r_n    <= i_in.negative_pressed;
                    r_dt   <= i_in.elapsed;
                    r_oor  <= 32'(i_in.channel) >= 32'(CHANNELS);
                end
            end
            S_LOAD: begin
                r_lvl   <= (zero_out || rev) ? '0 : e_lvl;
                r_tgt   <= (zero_out || rev) ? '0 : e_tgt;
                r_tap   <= zero_out ? 1'b0 : e_tap;
                r_hold  <= hold_upd;
                r_lp    <= r_p;
                r_ln    <= (r_op == OP_DUAL) ? r_n : e_ln;
                r_press <= (r_op == OP_DUAL) ? (r_p ^ r_n) : r_p;
                r_tneg  <= (r_op == OP_DUAL) && r_n;
            end
            S_PREP: begin
                r_floor <= floor_m;
                r_span  <= ONE_M - floor_m;
                // Tap flag follows only a single-key target
                if (r_press) r_tap <= tap_elig;
                r_tmag  <= r_press ? ONE_M : '0;
            end
            S_TDIV: begin
                if (div_done) r_tmag <= r_floor + div_quot[MAG_W-1:0];
            end
            S_TGT: begin
                if (tdiff_mag > NEAR_D) r_tgt <= tval;
            end
            S_DIR: begin
                if (rt_zero) begin
                    r_lvl <= r_tgt;
                end else if (step_sat) begin
                    r_step <= '1;
                end
            end
            S_SDIV: begin
                if (div_done) r_step <= div_quot;
            end
            S_RAMP: r_lvl <= lvl_ramp;
            S_DONE: begin
                if (out_free) begin
                    r_olevel <= lvl_x[LEVEL_W-1:0];
                    r_oramp  <= lmag > NEAR_D;
                    r_otap   <= r_tap;
                end
            end
            default: ;
        endcase
    end

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_ovalid;
    assign o_out.level      = r_olevel;
    assign o_out.ramping    = r_oramp;
    assign o_out.tap_active = r_otap;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_lvl <= ONE_S && r_lvl >= -ONE_S))
        else $error("level out of full-scale range at completion");

    a_ramp_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RAMP && r_tgt > r_lvl) |=> (r_lvl <= r_tgt && r_lvl >= $past(r_lvl)))
        else $error("rising ramp overshot or moved backward");

    a_ramp_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RAMP && r_tgt < r_lvl) |=> (r_lvl >= r_tgt && r_lvl <= $past(r_lvl)))
        else $error("falling ramp overshot or moved backward");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

endmodule
